[rtl/stfl_pkg.sv]
// Shared types, codes and defaults of the sample table frame locator.
package stfl_pkg;

  localparam int MAP_DEPTH_DEF    = 64;
  localparam int CHUNK_DEPTH_DEF  = 4096;
  localparam int SAMPLE_DEPTH_DEF = 16384;

  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 104;
  localparam int MAP_W      = 34;

  localparam logic [1:0] FN_LOAD_MAP    = 2'd0;
  localparam logic [1:0] FN_LOAD_CHUNK  = 2'd1;
  localparam logic [1:0] FN_LOAD_SIZE   = 2'd2;
  localparam logic [1:0] FN_LOCATE      = 2'd3;

  localparam logic [1:0] ST_FOUND  = 2'd0;
  localparam logic [1:0] ST_BEYOND = 2'd1;
  localparam logic [1:0] ST_NOMAP  = 2'd2;

  localparam logic [1:0] REG_MAP_ENTRIES   = 2'd0;
  localparam logic [1:0] REG_CHUNKS_IN_USE = 2'd1;
  localparam logic [1:0] REG_FIXED_SIZE    = 2'd2;

  typedef struct packed {
    logic start;
    logic set_beyond;
    logic set_nomap;
    logic map_cmp;
    logic advance;
    logic found;
    logic off_cap;
    logic mul;
    logic add;
    logic sum_acc;
    logic size_cap;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_locate;
    logic nchunk_zero;
    logic j_end;
    logic hit;
    logic over;
    logic last_chunk;
    logic fixed_zero;
    logic k_end;
    logic out_free;
  } sts_t;

endpackage

[rtl/stfl_ram.sv]
// Generic single-port-write, registered-read RAM.
module stfl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/stfl_ctrl.sv]
// Sequencer of the locate walk.
module stfl_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  stfl_pkg::sts_t sts,
  output stfl_pkg::cmd_t cmd
);
  import stfl_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_MAP_RD  = 10'b0000000010,
    S_MAP_CMP = 10'b0000000100,
    S_CHK     = 10'b0000001000,
    S_OFF     = 10'b0000010000,
    S_MUL     = 10'b0000100000,
    S_ADD     = 10'b0001000000,
    S_SUM_RD  = 10'b0010000000,
    S_SUM_ACC = 10'b0100000000,
    S_FINISH  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid && sts.is_locate) begin
          cmd.start = 1'b1;
          if (sts.nchunk_zero) begin
            cmd.set_beyond = 1'b1;
            state_nxt = S_FINISH;
          end else begin
            state_nxt = S_MAP_RD;
          end
        end
      end
      S_MAP_RD: begin
        state_nxt = sts.j_end ? S_CHK : S_MAP_CMP;
      end
      S_MAP_CMP: begin
        cmd.map_cmp = 1'b1;
        state_nxt = S_MAP_RD;
      end
      S_CHK: begin
        if (!sts.hit) begin
          cmd.set_nomap = 1'b1;
          state_nxt = S_FINISH;
        end else if (sts.over) begin
          cmd.found = 1'b1;
          state_nxt = S_OFF;
        end else if (sts.last_chunk) begin
          cmd.set_beyond = 1'b1;
          state_nxt = S_FINISH;
        end else begin
          cmd.advance = 1'b1;
          state_nxt = S_MAP_RD;
        end
      end
      S_OFF: begin
        cmd.off_cap = 1'b1;
        state_nxt = sts.fixed_zero ? S_SUM_RD : S_MUL;
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        cmd.add = 1'b1;
        state_nxt = S_FINISH;
      end
      S_SUM_RD: begin
        state_nxt = S_SUM_ACC;
      end
      S_SUM_ACC: begin
        if (sts.k_end) begin
          cmd.size_cap = 1'b1;
          state_nxt = S_FINISH;
        end else begin
          cmd.sum_acc = 1'b1;
          state_nxt = S_SUM_RD;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/stfl_dp.sv]
// Tables, configuration registers, walk counters and result register.
module stfl_dp #(
  parameter int MAP_DEPTH    = stfl_pkg::MAP_DEPTH_DEF,
  parameter int CHUNK_DEPTH  = stfl_pkg::CHUNK_DEPTH_DEF,
  parameter int SAMPLE_DEPTH = stfl_pkg::SAMPLE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [1:0]                       cfg_index,
  input  logic [31:0]                      cfg_data,
  input  logic                             in_fire,
  input  logic [1:0]                       in_func,
  input  logic [stfl_pkg::IN_DATA_W-1:0]   in_data,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [stfl_pkg::OUT_DATA_W-1:0]  out_data,
  output logic [1:0]                       out_status,
  input  stfl_pkg::cmd_t                   cmd,
  output stfl_pkg::sts_t                   sts
);
  import stfl_pkg::*;

  localparam int MAW = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int CAW = (CHUNK_DEPTH > 1) ? $clog2(CHUNK_DEPTH) : 1;
  localparam int SAW = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
  localparam int MNW = $clog2(MAP_DEPTH + 1);
  localparam int CNW = $clog2(CHUNK_DEPTH + 1);

  logic [13:0] f_slot;
  logic [11:0] f_first;
  logic [13:0] f_per;
  logic [7:0]  f_desc;
  logic [31:0] f_word;
  logic [13:0] f_frame;
  logic [31:0] slot_x;

  assign f_slot  = in_data[13:0];
  assign f_first = in_data[25:14];
  assign f_per   = in_data[39:26];
  assign f_desc  = in_data[47:40];
  assign f_word  = in_data[79:48];
  assign f_frame = in_data[93:80];
  assign slot_x  = 32'(f_slot);

  logic [6:0]  map_entries_r;
  logic [12:0] chunks_in_use_r;
  logic [31:0] fixed_size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_entries_r   <= '0;
      chunks_in_use_r <= '0;
      fixed_size_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAP_ENTRIES:   map_entries_r   <= cfg_data[6:0];
        REG_CHUNKS_IN_USE: chunks_in_use_r <= cfg_data[12:0];
        REG_FIXED_SIZE:    fixed_size_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [MNW-1:0] nmap;
  logic [CNW-1:0] nchunk;

  assign nmap   = (32'(map_entries_r) > MAP_DEPTH) ? MNW'(MAP_DEPTH) : MNW'(map_entries_r);
  assign nchunk = (32'(chunks_in_use_r) > CHUNK_DEPTH) ? CNW'(CHUNK_DEPTH)
                                                       : CNW'(chunks_in_use_r);

  logic [CAW-1:0]   i_r;
  logic [MNW-1:0]   j_r;
  logic [13:0]      k_r;
  logic [14:0]      total_r;
  logic [13:0]      frame_r;
  logic             hit_r;
  logic [13:0]      sel_count_r;
  logic [7:0]       sel_desc_r;
  logic [13:0]      pos_r;
  logic [31:0]      offset_r;
  logic [31:0]      size_r;
  logic [45:0]      prod_r;
  logic [1:0]       st_r;

  logic [MAP_W-1:0] map_rdata;
  logic [31:0]      chunk_rdata;
  logic [31:0]      size_rdata;
  logic [31:0]      k_x;
  logic [31:0]      size_eff;
  logic [14:0]      sum;
  logic [11:0]      m_first;
  logic [13:0]      m_count;
  logic [7:0]       m_desc;

  assign k_x      = 32'(k_r);
  assign size_eff = (k_x >= SAMPLE_DEPTH) ? 32'd0 : size_rdata;
  assign m_first  = map_rdata[33:22];
  assign m_count  = map_rdata[21:8];
  assign m_desc   = map_rdata[7:0];
  assign sum      = total_r + 15'(sel_count_r);

  stfl_ram #(.WIDTH(MAP_W), .DEPTH(MAP_DEPTH)) u_map_ram (
    .clk   (clk),
    .we    (in_fire && in_func == FN_LOAD_MAP && slot_x < MAP_DEPTH),
    .waddr (slot_x[MAW-1:0]),
    .wdata ({f_first, f_per, f_desc}),
    .raddr (j_r[MAW-1:0]),
    .rdata (map_rdata)
  );

  stfl_ram #(.WIDTH(32), .DEPTH(CHUNK_DEPTH)) u_chunk_ram (
    .clk   (clk),
    .we    (in_fire && in_func == FN_LOAD_CHUNK && slot_x < CHUNK_DEPTH),
    .waddr (slot_x[CAW-1:0]),
    .wdata (f_word),
    .raddr (i_r),
    .rdata (chunk_rdata)
  );

  stfl_ram #(.WIDTH(32), .DEPTH(SAMPLE_DEPTH)) u_size_ram (
    .clk   (clk),
    .we    (in_fire && in_func == FN_LOAD_SIZE && slot_x < SAMPLE_DEPTH),
    .waddr (slot_x[SAW-1:0]),
    .wdata (f_word),
    .raddr (k_x[SAW-1:0]),
    .rdata (size_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      i_r     <= '0;
      j_r     <= '0;
      total_r <= '0;
      hit_r   <= 1'b0;
      frame_r <= f_frame;
    end
    if (cmd.map_cmp) begin
      if (32'(m_first) <= 32'(i_r)) begin
        hit_r       <= 1'b1;
        sel_count_r <= m_count;
        sel_desc_r  <= m_desc;
      end
      j_r <= j_r + 1'b1;
    end
    if (cmd.advance) begin
      i_r     <= i_r + 1'b1;
      j_r     <= '0;
      hit_r   <= 1'b0;
      total_r <= sum;
    end
    if (cmd.found) begin
      pos_r <= frame_r - total_r[13:0];
      st_r  <= ST_FOUND;
    end
    if (cmd.set_beyond) begin
      st_r <= ST_BEYOND;
    end
    if (cmd.set_nomap) begin
      st_r <= ST_NOMAP;
    end
    if (cmd.off_cap) begin
      offset_r <= chunk_rdata;
      k_r      <= frame_r - pos_r;
    end
    if (cmd.mul) begin
      prod_r <= 46'(fixed_size_r) * 46'(pos_r);
    end
    if (cmd.add) begin
      offset_r <= offset_r + prod_r[31:0];
      size_r   <= fixed_size_r;
    end
    if (cmd.sum_acc) begin
      offset_r <= offset_r + size_eff;
      k_r      <= k_r + 1'b1;
    end
    if (cmd.size_cap) begin
      size_r <= size_eff;
    end
  end

  logic        out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [1:0]  out_status_r;
  logic [31:0] i_x;
  logic        is_found;

  assign i_x      = 32'(i_r);
  assign is_found = (st_r == ST_FOUND);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= st_r;
      out_data_r   <= {6'd0,
                       is_found ? size_r : 32'd0,
                       is_found ? offset_r : 32'd0,
                       is_found ? pos_r : 14'd0,
                       is_found ? sel_desc_r : 8'd0,
                       (st_r == ST_BEYOND) ? 12'd0 : i_x[11:0]};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_data   = out_data_r;
  assign out_status = out_status_r;

  assign sts.is_locate   = (in_func == FN_LOCATE);
  assign sts.nchunk_zero = (nchunk == '0);
  assign sts.j_end       = (j_r == nmap);
  assign sts.hit         = hit_r;
  assign sts.over        = (sum > {1'b0, frame_r});
  assign sts.last_chunk  = ((i_x + 32'd1) == 32'(nchunk));
  assign sts.fixed_zero  = (fixed_size_r == 32'd0);
  assign sts.k_end       = (k_r == frame_r);
  assign sts.out_free    = !out_valid_r || out_tready;

endmodule

[rtl/sample_table_frame_locator.sv]
// Sample table frame locator top level.
// Holds a sample-to-chunk map, a chunk offset table and a sample size table,
// each written by one load word, and answers a locate word with one result
// word. Loads give no result. A locate walks the chunks from the first one; for
// every chunk the controller scans all active map entries through the map RAM
// port. Once the frame's chunk is found, the offset is the chunk's offset plus a
// product with a fixed sample size, or plus a sum of sizes read through the size
// RAM port. The result waits in an output register; loads are taken while it
// waits, but a further result stalls the controller until that register is
// free. Status 0 is found, 1 a frame beyond the tables, 2 a chunk without a map
// entry.
module sample_table_frame_locator #(
  parameter int MAP_DEPTH    = stfl_pkg::MAP_DEPTH_DEF,
  parameter int CHUNK_DEPTH  = stfl_pkg::CHUNK_DEPTH_DEF,
  parameter int SAMPLE_DEPTH = stfl_pkg::SAMPLE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [31:0]                     cfg_data,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // slot, first_chunk, per_chunk, desc_in, word, frame
  input  logic [stfl_pkg::IN_DATA_W-1:0]  in_tdata,
  // func
  input  logic [1:0]                      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // chunk_index, desc_out, sample_in_chunk, frame_offset, frame_size
  output logic [stfl_pkg::OUT_DATA_W-1:0] out_tdata,
  // status
  output logic [1:0]                      out_tuser
);
  import stfl_pkg::*;

  cmd_t cmd;
  sts_t sts;

  stfl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  stfl_dp #(
    .MAP_DEPTH    (MAP_DEPTH),
    .CHUNK_DEPTH  (CHUNK_DEPTH),
    .SAMPLE_DEPTH (SAMPLE_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_fire    (in_tvalid && in_tready),
    .in_func    (in_tuser),
    .in_data    (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_data   (out_tdata),
    .out_status (out_tuser),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

[sim/tb_sample_table_frame_locator.sv]
// Testbench for the sample table frame locator: random load and locate words.
module tb_sample_table_frame_locator;
  import stfl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NMAP = MAP_DEPTH_DEF;
  localparam int NCHUNK = CHUNK_DEPTH_DEF;
  localparam int NSAMPLE = SAMPLE_DEPTH_DEF;
  localparam int SIZE_SPAN = 320;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]  func;
    logic [13:0] slot;
    logic [11:0] first;
    logic [13:0] count;
    logic [7:0]  desc;
    logic [31:0] word;
    logic [13:0] frame;
  } table_word_t;

  typedef struct {
    logic [1:0]  status;
    logic [11:0] chunk;
    logic [7:0]  desc;
    logic [13:0] pos;
    logic [31:0] offset;
    logic [31:0] size;
  } locate_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0] out_tuser;

  sample_table_frame_locator u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

  // predictor state
  logic [11:0] pm_first [NMAP];
  logic [13:0] pm_count [NMAP];
  logic [7:0]  pm_desc [NMAP];
  logic [31:0] pm_offset [NCHUNK];
  logic [31:0] pm_size [NSAMPLE];
  logic [6:0]  pm_entries = '0;
  logic [12:0] pm_chunks = '0;
  logic [31:0] pm_fixed = '0;

  // generator view of the map
  int gen_first [NMAP];
  int gen_count [NMAP];

  table_word_t pending_words[$];
  locate_t expected_locates[$];
  table_word_t cur_word;
  int send_idle = 0;
  int recv_idle = 0;
  int failures = 0;

  function automatic locate_t locate_frame(logic [13:0] frame);
    locate_t r;
    int unsigned nmap, nchunk, total, pos, sel, off;
    bit hit;
    r = '{default: '0};
    r.status = ST_BEYOND;
    nmap = (pm_entries > NMAP) ? NMAP : pm_entries;
    nchunk = (pm_chunks > NCHUNK) ? NCHUNK : pm_chunks;
    total = 0;
    for (int unsigned i = 0; i < nchunk; i++) begin
      hit = 0;
      sel = 0;
      for (int unsigned j = 0; j < nmap; j++) begin
        if (i >= pm_first[j]) begin
          sel = j;
          hit = 1;
        end
      end
      if (!hit) begin
        r.status = ST_NOMAP;
        r.chunk = i[11:0];
        return r;
      end
      total += pm_count[sel];
      if (total > frame) begin
        pos = pm_count[sel] - (total - frame);
        off = pm_offset[i];
        if (pm_fixed != 0) begin
          off = off + pm_fixed * pos;
          r.size = pm_fixed;
        end else begin
          for (int unsigned k = frame - pos; k < frame; k++) off = off + pm_size[k];
          r.size = pm_size[frame];
        end
        r.status = ST_FOUND;
        r.chunk = i[11:0];
        r.desc = pm_desc[sel];
        r.pos = pos[13:0];
        r.offset = off;
        return r;
      end
    end
    return r;
  endfunction

  function automatic void apply_word(table_word_t w);
    case (w.func)
      FN_LOAD_MAP: begin
        if (w.slot < NMAP) begin
          pm_first[w.slot] = w.first;
          pm_count[w.slot] = w.count;
          pm_desc[w.slot] = w.desc;
        end
      end
      FN_LOAD_CHUNK: if (w.slot < NCHUNK) pm_offset[w.slot] = w.word;
      FN_LOAD_SIZE: if (w.slot < NSAMPLE) pm_size[w.slot] = w.word;
      default: expected_locates.insert(expected_locates.size(), locate_frame(w.frame));
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) apply_word(cur_word);
      if (!in_tvalid || in_tready) begin
        if (pending_words.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
          cur_word = pending_words.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= cur_word.func;
          in_tdata <= {2'b0, cur_word.frame, cur_word.word, cur_word.desc, cur_word.count,
                       cur_word.first, cur_word.slot};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    locate_t e;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_locates.size() == 0) begin
          $error("unexpected result word status=%0d", out_tuser);
          failures++;
        end else begin
          e = expected_locates.pop_front();
          if (out_tuser !== e.status) begin
            $error("status exp %0d got %0d", e.status, out_tuser); failures++;
          end
          if (out_tdata[11:0] !== e.chunk) begin
            $error("chunk_index exp %0d got %0d", e.chunk, out_tdata[11:0]); failures++;
          end
          if (out_tdata[19:12] !== e.desc) begin
            $error("desc_out exp %0d got %0d", e.desc, out_tdata[19:12]); failures++;
          end
          if (out_tdata[33:20] !== e.pos) begin
            $error("sample_in_chunk exp %0d got %0d", e.pos, out_tdata[33:20]); failures++;
          end
          if (out_tdata[65:34] !== e.offset) begin
            $error("frame_offset exp %h got %h", e.offset, out_tdata[65:34]); failures++;
          end
          if (out_tdata[97:66] !== e.size) begin
            $error("frame_size exp %h got %h", e.size, out_tdata[97:66]); failures++;
          end
        end
      end
      out_tready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MAP_ENTRIES: pm_entries = val[6:0];
      REG_CHUNKS_IN_USE: pm_chunks = val[12:0];
      REG_FIXED_SIZE: pm_fixed = val;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_words.size() > 0 || in_tvalid || expected_locates.size() > 0);
    repeat (20) @(posedge clk);
  endtask

  function automatic void push_load(logic [1:0] func, int slot, int first, int count,
                                    int desc, logic [31:0] word);
    table_word_t w;
    w.func = func;
    w.slot = slot[13:0];
    w.first = first[11:0];
    w.count = count[13:0];
    w.desc = desc[7:0];
    w.word = word;
    w.frame = 14'($urandom_range(0, 16383));
    if (func == FN_LOAD_MAP && slot < NMAP) begin
      gen_first[slot] = first;
      gen_count[slot] = count;
    end
    pending_words.insert(pending_words.size(), w);
  endfunction

  function automatic void push_locate(int frame);
    table_word_t w;
    w.func = FN_LOCATE;
    w.slot = 14'($urandom_range(0, 16383));
    w.first = 12'($urandom_range(0, 4095));
    w.count = 14'($urandom_range(0, 16383));
    w.desc = 8'($urandom_range(0, 255));
    w.word = $urandom;
    w.frame = frame[13:0];
    pending_words.insert(pending_words.size(), w);
  endfunction

  function automatic int sample_reach(int ne, int nc);
    int total, sel;
    bit hit;
    total = 0;
    for (int i = 0; i < nc; i++) begin
      hit = 0;
      sel = 0;
      for (int j = 0; j < ne; j++) begin
        if (i >= gen_first[j]) begin
          sel = j;
          hit = 1;
        end
      end
      if (!hit) return total;
      total += gen_count[sel];
    end
    return total;
  endfunction

  function automatic void push_map_entry(int j, int nc, int max_count);
    int first, count;
    if (j == 0) first = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
    else if ($urandom_range(0, 9) == 0) first = $urandom_range(0, nc);
    else first = gen_first[j-1] + $urandom_range(0, 2);
    if (first > 4095) first = 4095;
    count = (max_count > 20 && $urandom_range(0, 5) == 0) ?
            $urandom_range(0, max_count) : $urandom_range(0, 20);
    push_load(FN_LOAD_MAP, j, first, count, $urandom_range(0, 255), $urandom);
  endfunction

  task automatic run_phase(int map_reg, int chunk_reg, logic [31:0] fixed, int n_rand,
                           int max_count);
    int ne, nc, reach, frame, kind;
    wait_drained();
    write_reg(REG_MAP_ENTRIES, map_reg);
    write_reg(REG_CHUNKS_IN_USE, chunk_reg);
    write_reg(REG_FIXED_SIZE, fixed);
    ne = (pm_entries > NMAP) ? NMAP : pm_entries;
    nc = (pm_chunks > NCHUNK) ? NCHUNK : pm_chunks;
    for (int j = 0; j < ne; j++) begin
      if (nc > 256) push_load(FN_LOAD_MAP, j, 0, 0, $urandom_range(0, 255), $urandom);
      else push_map_entry(j, nc, max_count);
    end
    if (nc <= 256) begin
      for (int i = 0; i < nc; i++) push_load(FN_LOAD_CHUNK, i, 0, 0, 0, $urandom);
    end
    for (int n = 0; n < n_rand; n++) begin
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        reach = sample_reach(ne, nc);
        frame = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16383) :
                $urandom_range(0, reach + 3);
        if (frame > 16383) frame = 16383;
        if (fixed == 0 && frame < reach && frame >= SIZE_SPAN)
          frame = $urandom_range(0, SIZE_SPAN - 1);
        push_locate(frame);
      end else if (kind == 6 && ne > 0 && nc <= 256) begin
        push_map_entry($urandom_range(0, ne - 1), nc, max_count);
      end else if (kind == 7 && nc > 0 && nc <= 256) begin
        push_load(FN_LOAD_CHUNK, $urandom_range(0, nc - 1), 0, 0, 0, $urandom);
      end else if (kind == 8) begin
        push_load(FN_LOAD_SIZE, $urandom_range(0, SIZE_SPAN - 1), 0, 0, 0, $urandom);
      end else begin
        push_load(2'($urandom_range(0, 2)), $urandom_range(NCHUNK, 16383),
                  $urandom_range(0, 4095), $urandom_range(0, 16383),
                  $urandom_range(0, 255), $urandom);
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send_idle = 18;
    recv_idle = 78;
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    write_reg(REG_MAP_ENTRIES, 3);
    write_reg(REG_CHUNKS_IN_USE, 8);
    write_reg(REG_FIXED_SIZE, 0);
    for (int k = 0; k < SIZE_SPAN; k++)
      push_load(FN_LOAD_SIZE, k, 0, 0, 0, (k == 0) ? 32'hFFFF_FFFF : $urandom);
    push_load(FN_LOAD_MAP, 0, 0, 3, 8'hA5, 0);
    push_load(FN_LOAD_MAP, 1, 2, 0, 8'h00, 0);
    push_load(FN_LOAD_MAP, 2, 5, 20, 8'hFF, 0);
    for (int i = 0; i < 8; i++)
      push_load(FN_LOAD_CHUNK, i, 0, 0, 0, (i == 0) ? 32'hFFFF_FFF0 : $urandom);
    push_load(FN_LOAD_MAP, 16383, 4095, 16383, 255, 32'hFFFF_FFFF);
    push_load(FN_LOAD_CHUNK, NCHUNK, 0, 0, 0, 32'h1234_5678);
    push_load(FN_LOAD_SIZE, 16383, 0, 0, 0, 32'hDEAD_BEEF);
    push_locate(0);
    push_locate(2);
    push_locate(3);
    push_locate(6);
    push_locate(7);
    push_locate(66);
    push_locate(67);
    push_locate(16383);

    run_phase(4, 12, 0, 90, 20);
    run_phase(127, 6, 0, 60, 20);
    send_idle = 78;
    recv_idle = 18;
    run_phase(5, 16, 32'hFFFF_FFFF, 90, 16383);
    run_phase(0, 5, 0, 12, 20);
    run_phase(1, 8191, 32'hFFFF_FFFF, 3, 0);
    send_idle = 0;
    recv_idle = 0;
    run_phase(8, 10, $urandom_range(1, 1000), 110, 16383);
    run_phase(6, 0, 0, 12, 20);
    run_phase(3, 14, 0, 110, 20);
    run_phase($urandom_range(1, 10), $urandom_range(1, 16), 0, 110, 20);

    wait_drained();
    repeat (200) @(posedge clk);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
